// File: rtl/mode_residency_accumulator_assert.svh
// Assertion macros for the mode residency accumulator.
// Both macros sample on clk_i; MRA_ASSERT is also disabled while rst_ni is low.
`ifndef MODE_RESIDENCY_ACCUMULATOR_ASSERT_SVH
`define MODE_RESIDENCY_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTH
`define MRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mra assertion failed");
`define MRA_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mra assertion failed");
`else
`define MRA_ASSERT(lbl, prop)
`define MRA_ASSERT_ANY(lbl, prop)
`endif

`endif

// File: rtl/mra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mra_pkg;

  localparam logic [4:0] MODE_COUNT_RESET = 5'd16;
  localparam int         RESULT_LIMIT     = 16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_XFER   = 2'd1,
    OP_GET    = 2'd2,
    OP_DELTA  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] now;
    logic [3:0]  mode;
  } in_t;

  typedef struct packed {
    logic [3:0]  mode_index;
    logic [63:0] value;
    logic [63:0] stamp;
    logic        last;
  } out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_readout;
    logic out_free;
    logic idx_last;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/mra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mra_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mra_pkg::sts_t sts_i,
  output mra_pkg::cmd_t cmd_o
);

  mra_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      mra_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mra_pkg::ST_EXEC;
        end
      end
      mra_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.op_readout ? mra_pkg::ST_EMIT : mra_pkg::ST_IDLE;
      end
      mra_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.out_free && sts_i.idx_last) begin
          state_d = mra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mra_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mra_datapath #(
  parameter int NumModes = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mra_pkg::in_t  in_data_i,
  input  logic          cfg_valid_i,
  input  logic [4:0]    cfg_data_i,
  input  mra_pkg::cmd_t cmd_i,
  output mra_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mra_pkg::out_t out_data_o
);

  localparam int IdxW = (NumModes > 1) ? $clog2(NumModes) : 1;
  localparam logic [4:0] Cap = 5'(NumModes);

  logic [4:0]      mode_count_q;
  logic [1:0]      op_q;
  logic [63:0]     now_q;
  logic [3:0]      mode_q;
  logic [63:0]     stamp_q;
  logic [63:0]     res_q  [NumModes];
  logic [63:0]     snap_q [NumModes];
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  mra_pkg::out_t   out_q;

  logic [4:0]  last_m1;
  logic        out_load;
  logic        mode_ok;
  logic [63:0] elapsed;
  logic [63:0] rd_res;
  logic [63:0] rd_snap;

  always_comb begin
    if (mode_count_q == 5'd0) begin
      last_m1 = 5'd0;
    end else if (mode_count_q > Cap) begin
      last_m1 = Cap - 5'd1;
    end else begin
      last_m1 = mode_count_q - 5'd1;
    end
  end

  assign mode_ok  = {1'b0, mode_q} < 5'(NumModes);
  assign elapsed  = now_q - stamp_q;
  assign out_load = cmd_i.emit && (!out_valid_q || out_ready_i);
  assign rd_res   = res_q[idx_q];
  assign rd_snap  = snap_q[idx_q];

  assign sts_o.op_readout = (op_q == mra_pkg::OP_GET) || (op_q == mra_pkg::OP_DELTA);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.idx_last   = 5'(idx_q) == last_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= mra_pkg::MODE_COUNT_RESET;
    end else if (cfg_valid_i) begin
      mode_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.opcode;
      now_q  <= in_data_i.now;
      mode_q <= in_data_i.mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
      for (int i = 0; i < NumModes; i++) begin
        res_q[i]  <= '0;
        snap_q[i] <= '0;
      end
    end else begin
      if (cmd_i.exec) begin
        stamp_q <= now_q;
        if (op_q == mra_pkg::OP_CLEAR) begin
          for (int i = 0; i < NumModes; i++) begin
            res_q[i] <= '0;
          end
        end else if (mode_ok) begin
          res_q[mode_q[IdxW-1:0]] <= res_q[mode_q[IdxW-1:0]] + elapsed;
        end
      end
      if (out_load) begin
        snap_q[idx_q] <= rd_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.exec) begin
      idx_q <= '0;
    end else if (out_load) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.mode_index <= 4'(idx_q);
      out_q.value      <= (op_q == mra_pkg::OP_DELTA) ? (rd_res - rd_snap) : rd_res;
      out_q.stamp      <= stamp_q;
      out_q.last       <= sts_o.idx_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/mode_residency_accumulator.sv
// Channel  Direction  Payload               Handshake
// in       input      mra_pkg::in_t         in_valid_i / in_ready_o
// out      output     mra_pkg::out_t        out_valid_o / out_ready_i
// cfg      input      mode count, 5 bits    cfg_valid_i / cfg_ready_o
//
// Clear and transition: accept, then the update in the exec state, then back to idle.
// A readout emits one entry a cycle, unless stalled, for n = 1 to NumModes effective modes.
// The emit walk stalls while the output register holds an untaken beat.
// Reset clears all accumulators, snapshots and the stamp at once; no sweep follows.
// A new item is accepted as soon as the last beat of a readout is registered.
`timescale 1ns / 1ps
`default_nettype none

`include "mode_residency_accumulator_assert.svh"

module mode_residency_accumulator #(
  parameter int MAX_MODES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mra_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mra_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [4:0]    cfg_data_i
);

  localparam int NumModes =
    (MAX_MODES < mra_pkg::RESULT_LIMIT) ? MAX_MODES : mra_pkg::RESULT_LIMIT;

  mra_pkg::cmd_t cmd;
  mra_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mra_datapath #(
    .NumModes (NumModes)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `MRA_ASSERT(a_accept_then_exec, (in_valid_i && in_ready_o) |=> cmd.exec)
  `MRA_ASSERT(a_readout_starts_walk, (cmd.exec && sts.op_readout) |=> cmd.emit)
  `MRA_ASSERT(a_walk_ends, (cmd.emit && sts.out_free && sts.idx_last) |=> !cmd.emit)
  `MRA_ASSERT_ANY(a_no_accept_in_walk, cmd.emit |-> !in_ready_o)

endmodule

`default_nettype wire
